/* sv/assert_macros.svh */
// Assertion macros shared by the cache simulator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* sv/sacl_pkg.sv */
// Shared types, codes and constants of the set-associative cache simulator.
package sacl_pkg;

  localparam int DEF_MAX_SET_BITS  = 8;
  localparam int DEF_MAX_WAYS      = 8;
  localparam int DEF_ADDRESS_WIDTH = 64;
  localparam int DEF_AGE_WIDTH     = 32;

  localparam int ADDR_PORT_W = 64;
  localparam int CNT_W       = 32;
  localparam int ACT_W       = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 6;
  localparam int SEFF_W      = 5;
  localparam int SHAMT_W     = 7;

  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_STORE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MODIFY = 2'd2;
  localparam logic [ACT_W-1:0] ACT_FETCH  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

  localparam logic [3:0] RST_SET_BITS   = 4'd4;
  localparam logic [3:0] RST_WAYS       = 4'd1;
  localparam logic [5:0] RST_BLOCK_BITS = 6'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_WRITE
  } sacl_state_e;

  typedef struct packed {
    logic load;
    logic rd;
    logic eval;
    logic commit;
    logic last;
  } sacl_cmd_t;

endpackage

/* sv/sacl_ctrl.sv */
// Access sequencer: steps each load, store or modify word through read, evaluate and write-back; a fetch is dropped.
module sacl_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [sacl_pkg::ACT_W-1:0]        action_i,
  output logic                              busy_o,
  output sacl_pkg::sacl_cmd_t               cmd_o
);
  import sacl_pkg::*;

  sacl_state_e state_q, state_d;
  logic        two_q, two_d;
  logic        second_q, second_d;
  logic        more_pass;

  assign more_pass = two_q && !second_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      two_q    <= 1'b0;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      two_q    <= two_d;
      second_q <= second_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    two_d    = two_q;
    second_d = second_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i && (action_i != ACT_FETCH)) begin
          state_d  = ST_READ;
          two_d    = (action_i == ACT_MODIFY);
          second_d = 1'b0;
        end
      end
      ST_READ:  state_d = ST_EVAL;
      ST_EVAL:  state_d = ST_WRITE;
      ST_WRITE: begin
        if (more_pass) begin
          state_d  = ST_READ;
          second_d = 1'b1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_READ:  cmd_o.rd = 1'b1;
      ST_EVAL:  cmd_o.eval = 1'b1;
      ST_WRITE: begin
        cmd_o.commit = 1'b1;
        cmd_o.last   = !more_pass;
      end
      default: busy_o = 1'b1;
    endcase
  end

endmodule

/* sv/sacl_dp.sv */
// Cache datapath: configuration, set memory, hit and victim search, totals.
module sacl_dp #(
  parameter int MAX_SET_BITS  = sacl_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS      = sacl_pkg::DEF_MAX_WAYS,
  parameter int ADDRESS_WIDTH = sacl_pkg::DEF_ADDRESS_WIDTH,
  parameter int AGE_WIDTH     = sacl_pkg::DEF_AGE_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sacl_pkg::sacl_cmd_t               cmd_i,
  input  logic                              cfg_we_i,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic [sacl_pkg::ADDR_PORT_W-1:0]  address_i,
  output logic                              done_o,
  output logic                              hit_o,
  output logic                              miss_o,
  output logic                              eviction_o,
  output logic [sacl_pkg::CNT_W-1:0]        hits_total_o,
  output logic [sacl_pkg::CNT_W-1:0]        misses_total_o,
  output logic [sacl_pkg::CNT_W-1:0]        evictions_total_o,
  output logic                              last_of_item_o
);
  import sacl_pkg::*;

  localparam int ROWS  = 2 ** MAX_SET_BITS;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NW2   = 2 ** $clog2(MAX_WAYS);
  localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;
  localparam logic [CNT_W-1:0]     CNT_MAX = '1;

  // configuration
  logic [3:0] set_bits_q;
  logic [3:0] ways_q;
  logic [5:0] block_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= RST_SET_BITS;
      ways_q       <= RST_WAYS;
      block_bits_q <= RST_BLOCK_BITS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SET_BITS:   set_bits_q   <= cfg_wdata_i[3:0];
        CFG_WAYS:       ways_q       <= cfg_wdata_i[3:0];
        CFG_BLOCK_BITS: block_bits_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // address split
  logic [ADDRESS_WIDTH-1:0] addr;
  logic [SEFF_W-1:0]        s_eff;
  logic [SHAMT_W-1:0]       tag_sh;
  logic [ADDRESS_WIDTH-1:0] set_full;
  logic [MAX_SET_BITS-1:0]  set_mask;
  logic [MAX_SET_BITS-1:0]  set_q;
  logic [ADDRESS_WIDTH-1:0] tag_q;
  logic [MAX_WAYS-1:0]      lane_en;

  assign addr   = address_i[ADDRESS_WIDTH-1:0];
  assign s_eff  = (SEFF_W'(set_bits_q) > SEFF_W'(MAX_SET_BITS)) ?
                  SEFF_W'(MAX_SET_BITS) : SEFF_W'(set_bits_q);
  assign tag_sh = SHAMT_W'(s_eff) + SHAMT_W'(block_bits_q);
  assign set_full = addr >> block_bits_q;

  always_comb begin
    for (int i = 0; i < MAX_SET_BITS; i++) begin
      set_mask[i] = (i < int'(s_eff));
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      lane_en[w] = (w == 0) || (int'(ways_q) > w);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      set_q <= set_full[MAX_SET_BITS-1:0] & set_mask;
      tag_q <= addr >> tag_sh;
    end
  end

  // set memory
  logic [MAX_WAYS-1:0]                 vmem [ROWS];
  logic [MAX_WAYS-1:0][ADDRESS_WIDTH-1:0] tmem [ROWS];
  logic [MAX_WAYS-1:0][AGE_WIDTH-1:0]  amem [ROWS];
  logic [ROWS-1:0]                     row_vld_q;
  logic                                rd_row_q;
  logic [MAX_WAYS-1:0]                 rd_v_q;
  logic [MAX_WAYS-1:0][ADDRESS_WIDTH-1:0] rd_t_q;
  logic [MAX_WAYS-1:0][AGE_WIDTH-1:0]  rd_a_q;
  logic [MAX_WAYS-1:0]                 new_v;
  logic [MAX_WAYS-1:0][ADDRESS_WIDTH-1:0] new_t;
  logic [MAX_WAYS-1:0][AGE_WIDTH-1:0]  new_a;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      vmem[set_q] <= new_v;
      tmem[set_q] <= new_t;
      amem[set_q] <= new_a;
    end
    if (cmd_i.rd) begin
      rd_v_q   <= vmem[set_q];
      rd_t_q   <= tmem[set_q];
      rd_a_q   <= amem[set_q];
      rd_row_q <= row_vld_q[set_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (cmd_i.commit) begin
      row_vld_q[set_q] <= 1'b1;
    end
  end

  // evaluate: age bump and tag compare
  logic [MAX_WAYS-1:0]                 ev_v_d, ev_v_q;
  logic [MAX_WAYS-1:0][ADDRESS_WIDTH-1:0] ev_t_d, ev_t_q;
  logic [MAX_WAYS-1:0][AGE_WIDTH-1:0]  ev_a_d, ev_a_q;
  logic [MAX_WAYS-1:0]                 ev_m_d, ev_m_q;

  always_comb begin
    ev_v_d = rd_row_q ? rd_v_q : '0;
    ev_t_d = rd_row_q ? rd_t_q : '0;
    ev_a_d = rd_row_q ? rd_a_q : '0;
    ev_m_d = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (ev_v_d[w] && lane_en[w]) begin
        if (ev_a_d[w] != AGE_MAX) begin
          ev_a_d[w] = ev_a_d[w] + AGE_WIDTH'(1);
        end
        ev_m_d[w] = (ev_t_d[w] == tag_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      ev_v_q <= ev_v_d;
      ev_t_q <= ev_t_d;
      ev_a_q <= ev_a_d;
      ev_m_q <= ev_m_d;
    end
  end

  // commit: pick the way, build the new row
  logic                 hit_any;
  logic [WAY_W-1:0]     hit_way;
  logic                 free_any;
  logic [WAY_W-1:0]     free_way;
  logic [WAY_W-1:0]     vic_way;
  logic [WAY_W-1:0]     tgt_way;
  logic [AGE_WIDTH-1:0] n_age [2*NW2];
  logic [WAY_W-1:0]     n_idx [2*NW2];
  logic [2*NW2-1:0]     n_ok;
  logic                 pick_r;

  always_comb begin
    hit_any  = |ev_m_q;
    free_any = |(~ev_v_q & lane_en);
    hit_way  = '0;
    free_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (ev_m_q[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!ev_v_q[w] && lane_en[w]) begin
        free_way = WAY_W'(w);
      end
    end
  end

  always_comb begin
    pick_r = 1'b0;
    n_ok   = '0;
    for (int i = 0; i < 2 * NW2; i++) begin
      n_age[i] = '0;
      n_idx[i] = '0;
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      n_ok[NW2 + w]  = lane_en[w];
      n_age[NW2 + w] = ev_a_q[w];
      n_idx[NW2 + w] = WAY_W'(w);
    end
    for (int i = NW2 - 1; i >= 1; i--) begin
      pick_r = n_ok[2*i+1] && (!n_ok[2*i] || (n_age[2*i+1] > n_age[2*i]));
      n_ok[i]  = n_ok[2*i] || n_ok[2*i+1];
      n_age[i] = pick_r ? n_age[2*i+1] : n_age[2*i];
      n_idx[i] = pick_r ? n_idx[2*i+1] : n_idx[2*i];
    end
    vic_way = n_idx[1];
  end

  always_comb begin
    priority if (hit_any) begin
      tgt_way = hit_way;
    end else if (free_any) begin
      tgt_way = free_way;
    end else begin
      tgt_way = vic_way;
    end
    new_v          = ev_v_q;
    new_t          = ev_t_q;
    new_a          = ev_a_q;
    new_v[tgt_way] = 1'b1;
    new_t[tgt_way] = tag_q;
    new_a[tgt_way] = '0;
  end

  // result and totals
  logic             evict;
  logic             done_q;
  logic             hit_q, miss_q, evict_q, last_q;
  logic [CNT_W-1:0] hcnt_q, mcnt_q, ecnt_q;

  assign evict = !hit_any && !free_any;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      hcnt_q <= '0;
      mcnt_q <= '0;
      ecnt_q <= '0;
    end else begin
      done_q <= cmd_i.commit;
      if (cmd_i.commit) begin
        if (hit_any && (hcnt_q != CNT_MAX)) begin
          hcnt_q <= hcnt_q + CNT_W'(1);
        end
        if (!hit_any && (mcnt_q != CNT_MAX)) begin
          mcnt_q <= mcnt_q + CNT_W'(1);
        end
        if (evict && (ecnt_q != CNT_MAX)) begin
          ecnt_q <= ecnt_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      hit_q   <= hit_any;
      miss_q  <= !hit_any;
      evict_q <= evict;
      last_q  <= cmd_i.last;
    end
  end

  assign done_o            = done_q;
  assign hit_o             = hit_q;
  assign miss_o            = miss_q;
  assign eviction_o        = evict_q;
  assign hits_total_o      = hcnt_q;
  assign misses_total_o    = mcnt_q;
  assign evictions_total_o = ecnt_q;
  assign last_of_item_o    = last_q;

endmodule

/* sv/set_assoc_cache_lru_sim.sv */
// Top level of the set-associative cache simulator with LRU replacement.
//
// Command channel: drive action_i and address_i with start_i high; the word
// is taken at a clock edge where start_i is high and busy_o is low.
// A load or a store makes one access, a modify makes a load then a store,
// an instruction fetch is taken and dropped with no result.
// Each access reads one set row from memory, bumps ages and compares tags
// across the enabled ways, then picks hit, free or oldest way and writes the row
// back. Its result shows on the result ports in the cycle after write-back,
// flagged by done_o for one cycle; last_of_item_o marks the final one.
// busy_o stays high from the accept edge through the last write-back, so a word
// is not taken before the previous one has written its final row back.
// Each access makes one read and one write of the set row memory.
// The receiver cannot stall: results must be taken when done_o is high.
// Configuration writes land at once through cfg_we_i, cfg_idx_i and
// cfg_wdata_i and are meant for idle time only.
// Reset clears the row valid flags (all lines empty) and totals, and sets the config to its defaults.
`include "assert_macros.svh"
module set_assoc_cache_lru_sim #(
  parameter int MAX_SET_BITS  = sacl_pkg::DEF_MAX_SET_BITS,
  parameter int MAX_WAYS      = sacl_pkg::DEF_MAX_WAYS,
  parameter int ADDRESS_WIDTH = sacl_pkg::DEF_ADDRESS_WIDTH,
  parameter int AGE_WIDTH     = sacl_pkg::DEF_AGE_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [sacl_pkg::ACT_W-1:0]        action_i,
  input  logic [sacl_pkg::ADDR_PORT_W-1:0]  address_i,
  input  logic                              cfg_we_i,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output logic                              done_o,
  output logic                              hit_o,
  output logic                              miss_o,
  output logic                              eviction_o,
  output logic [sacl_pkg::CNT_W-1:0]        hits_total_o,
  output logic [sacl_pkg::CNT_W-1:0]        misses_total_o,
  output logic [sacl_pkg::CNT_W-1:0]        evictions_total_o,
  output logic                              last_of_item_o
);
  import sacl_pkg::*;

  sacl_cmd_t cmd;

  sacl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .busy_o   (busy_o),
    .cmd_o    (cmd)
  );

  sacl_dp #(
    .MAX_SET_BITS  (MAX_SET_BITS),
    .MAX_WAYS      (MAX_WAYS),
    .ADDRESS_WIDTH (ADDRESS_WIDTH),
    .AGE_WIDTH     (AGE_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .address_i         (address_i),
    .done_o            (done_o),
    .hit_o             (hit_o),
    .miss_o            (miss_o),
    .eviction_o        (eviction_o),
    .hits_total_o      (hits_total_o),
    .misses_total_o    (misses_total_o),
    .evictions_total_o (evictions_total_o),
    .last_of_item_o    (last_of_item_o)
  );

  `ASSERT_IMP(a_hit_xor_miss, clk_i, rst_ni, done_o, hit_o != miss_o)
  `ASSERT_IMP(a_evict_on_miss, clk_i, rst_ni, done_o && eviction_o, miss_o)
  `ASSERT_NXT(a_commit_done, clk_i, rst_ni, cmd.commit, done_o)
  `ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start_i && !busy_o && (action_i != ACT_FETCH), busy_o)

endmodule

/* tb/tb.sv */
// Self-checking testbench for the set-associative LRU cache simulator.
`timescale 1ns / 100ps

module tb;
  import sacl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;
  localparam int LINES  = (1 << DEF_MAX_SET_BITS) * DEF_MAX_WAYS;
  localparam int SETTLE = 8;
  localparam int DRAIN  = 20;

  typedef struct packed {
    logic                   is_cfg;
    logic [ACT_W-1:0]       act;
    logic [ADDR_PORT_W-1:0] addr;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
  } plan_t;

  typedef struct packed {
    logic             hit;
    logic             miss;
    logic             evict;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evicts;
    logic             last;
  } outcome_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [ACT_W-1:0]       action = ACT_LOAD;
  logic [ADDR_PORT_W-1:0] address = '0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx = CFG_SET_BITS;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   done;
  logic                   hit;
  logic                   miss;
  logic                   eviction;
  logic [CNT_W-1:0]       hits_total;
  logic [CNT_W-1:0]       misses_total;
  logic [CNT_W-1:0]       evictions_total;
  logic                   last_of_item;

  set_assoc_cache_lru_sim dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .start_i           (start),
    .busy_o            (busy),
    .action_i          (action),
    .address_i         (address),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .done_o            (done),
    .hit_o             (hit),
    .miss_o            (miss),
    .eviction_o        (eviction),
    .hits_total_o      (hits_total),
    .misses_total_o    (misses_total),
    .evictions_total_o (evictions_total),
    .last_of_item_o    (last_of_item)
  );

  plan_t    plan_q[$];
  outcome_t outcome_q[$];
  int       plan_total = 0;
  int       plan_done = 0;
  int       errs = 0;
  int       quiet = 0;
  int       gap_left = 0;
  int       burst_left = 0;
  logic     word_taken = 1'b0;

  // shadow cache
  logic [3:0]  cur_set_bits = RST_SET_BITS;
  logic [3:0]  cur_ways = RST_WAYS;
  logic [5:0]  cur_block_bits = RST_BLOCK_BITS;
  bit          line_ok [LINES];
  bit   [63:0] line_tag [LINES];
  bit   [31:0] line_age [LINES];
  bit   [31:0] hit_cnt;
  bit   [31:0] miss_cnt;
  bit   [31:0] evict_cnt;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void sat_bump(ref bit [31:0] c);
    if (c != 32'hFFFF_FFFF) c = c + 32'd1;
  endfunction

  function automatic void cache_access(input logic [63:0] addr, input logic last);
    int unsigned s;
    int unsigned e;
    int unsigned base;
    int unsigned victim;
    logic [63:0] set_idx;
    logic [63:0] tag_v;
    bit   [31:0] oldest;
    bit          resolved;
    outcome_t    o;
    s = (cur_set_bits > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : cur_set_bits;
    e = (cur_ways == 0) ? 1 : ((cur_ways > DEF_MAX_WAYS) ? DEF_MAX_WAYS : cur_ways);
    set_idx = (addr >> cur_block_bits) & ((64'd1 << s) - 64'd1);
    tag_v = addr >> (s + cur_block_bits);
    base = 32'(set_idx) * DEF_MAX_WAYS;
    resolved = 1'b0;
    o = '0;
    for (int i = 0; i < e; i++) begin
      if (line_ok[base+i] && line_age[base+i] != 32'hFFFF_FFFF)
        line_age[base+i] = line_age[base+i] + 32'd1;
    end
    for (int i = 0; i < e; i++) begin
      if (!resolved && line_ok[base+i] && line_tag[base+i] == tag_v) begin
        sat_bump(hit_cnt);
        line_age[base+i] = '0;
        o.hit = 1'b1;
        resolved = 1'b1;
      end
    end
    if (!resolved) begin
      sat_bump(miss_cnt);
      o.miss = 1'b1;
      for (int i = 0; i < e; i++) begin
        if (!resolved && !line_ok[base+i]) begin
          line_ok[base+i] = 1'b1;
          line_tag[base+i] = tag_v;
          line_age[base+i] = '0;
          resolved = 1'b1;
        end
      end
    end
    if (!resolved) begin
      victim = 0;
      oldest = line_age[base];
      for (int i = 1; i < e; i++) begin
        if (line_age[base+i] > oldest) begin
          oldest = line_age[base+i];
          victim = i;
        end
      end
      sat_bump(evict_cnt);
      o.evict = 1'b1;
      line_tag[base+victim] = tag_v;
      line_age[base+victim] = '0;
    end
    o.hits = hit_cnt;
    o.misses = miss_cnt;
    o.evicts = evict_cnt;
    o.last = last;
    outcome_q.push_back(o);
  endfunction

  function automatic void predict_word(input logic [ACT_W-1:0] act, input logic [63:0] addr);
    case (act)
      ACT_LOAD, ACT_STORE: cache_access(addr, 1'b1);
      ACT_MODIFY: begin
        cache_access(addr, 1'b0);
        cache_access(addr, 1'b1);
      end
      ACT_FETCH: ;
    endcase
  endfunction

  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_SET_BITS:   cur_set_bits = data[3:0];
      CFG_WAYS:       cur_ways = data[3:0];
      CFG_BLOCK_BITS: cur_block_bits = data;
      CFG_NONE: ;
    endcase
  endfunction

  function automatic void cmp(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      errs++;
    end
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_word(input logic [ACT_W-1:0] act, input logic [63:0] addr);
    plan_t p;
    p = '0;
    p.act = act;
    p.addr = addr;
    plan_q.push_back(p);
    plan_total++;
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    plan_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.idx = idx;
    p.data = data;
    plan_q.push_back(p);
    plan_total++;
  endfunction

  function automatic void add_phase(input logic [3:0] sb, input logic [3:0] wy,
                                    input logic [5:0] bb, input int n);
    logic [63:0] pool[$];
    logic [63:0] hot0;
    logic [63:0] hot1;
    logic [63:0] smask;
    logic [63:0] omask;
    logic [63:0] set_v;
    logic [63:0] tag_v;
    logic [63:0] addr_v;
    logic [ACT_W-1:0] act_v;
    logic [1:0]  junk;
    int unsigned es;
    int unsigned ew;
    int unsigned r;
    int          made;
    junk = 2'($urandom);
    add_cfg(CFG_SET_BITS, {junk, sb});
    junk = 2'($urandom);
    add_cfg(CFG_WAYS, {junk, wy});
    add_cfg(CFG_BLOCK_BITS, bb);
    es = (sb > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : sb;
    ew = (wy == 0) ? 1 : ((wy > DEF_MAX_WAYS) ? DEF_MAX_WAYS : wy);
    smask = (64'd1 << es) - 64'd1;
    omask = (64'd1 << bb) - 64'd1;
    for (int k = 0; k < ew + $urandom_range(1, 3); k++) begin
      if ($urandom_range(0, 1) != 0) pool.push_back({$urandom, $urandom});
      else pool.push_back(64'($urandom_range(0, 15)));
    end
    hot0 = {$urandom, $urandom} & smask;
    hot1 = {$urandom, $urandom} & smask;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 8) act_v = ACT_FETCH;
      else begin
        case ($urandom_range(0, 2))
          0:       act_v = ACT_LOAD;
          1:       act_v = ACT_STORE;
          default: act_v = ACT_MODIFY;
        endcase
      end
      r = $urandom_range(0, 99);
      tag_v = pool[$urandom_range(0, pool.size() - 1)];
      if (r < 50) set_v = hot0;
      else if (r < 75) set_v = hot1;
      else set_v = {$urandom, $urandom} & smask;
      addr_v = (tag_v << (es + bb)) | (set_v << bb) | ({$urandom, $urandom} & omask);
      if (r >= 88) addr_v = {$urandom, $urandom};
      add_word(act_v, addr_v);
      if (act_v != ACT_FETCH) made++;
    end
  endfunction

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    plan_t                  nx;
    logic                   go;
    logic                   we;
    logic [ACT_W-1:0]       nx_act;
    logic [ADDR_PORT_W-1:0] nx_addr;
    logic [CFG_IDX_W-1:0]   nx_idx;
    logic [CFG_DATA_W-1:0]  nx_data;
    if (rst_n) begin
      go = start && !word_taken;
      we = 1'b0;
      nx_act = action;
      nx_addr = address;
      nx_idx = cfg_idx;
      nx_data = cfg_wdata;
      word_taken = 1'b0;
      if (outcome_q.size() == 0 && !busy && !start) quiet++;
      else quiet = 0;
      if (!go) begin
        if (gap_left != 0) gap_left--;
        else if (plan_q.size() != 0) begin
          nx = plan_q[0];
          if (!nx.is_cfg) begin
            void'(plan_q.pop_front());
            go = 1'b1;
            nx_act = nx.act;
            nx_addr = nx.addr;
            gap_left = pick_gap();
          end else if (quiet >= SETTLE) begin
            void'(plan_q.pop_front());
            we = 1'b1;
            nx_idx = nx.idx;
            nx_data = nx.data;
          end
        end
      end
      start <= go;
      cfg_we <= we;
      action <= nx_act;
      address <= nx_addr;
      cfg_idx <= nx_idx;
      cfg_wdata <= nx_data;
    end
  end

  // monitor: sample on the rising edge, check before predicting
  always @(posedge clk) begin
    outcome_t w;
    if (rst_n) begin
      if (done) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: done expected 0 actual 1, hits_total actual %0h",
                   $time, hits_total);
          errs++;
        end else begin
          w = outcome_q.pop_front();
          cmp("hit", 32'(w.hit), 32'(hit));
          cmp("miss", 32'(w.miss), 32'(miss));
          cmp("eviction", 32'(w.evict), 32'(eviction));
          cmp("hits_total", w.hits, hits_total);
          cmp("misses_total", w.misses, misses_total);
          cmp("evictions_total", w.evicts, evictions_total);
          cmp("last_of_item", 32'(w.last), 32'(last_of_item));
        end
      end
      if (cfg_we) begin
        apply_cfg(cfg_idx, cfg_wdata);
        plan_done++;
      end
      if (start && !busy) begin
        predict_word(action, address);
        word_taken = 1'b1;
        plan_done++;
      end
    end
  end

  initial begin
    logic [63:0] t;
    // reset geometry: 16 sets, one way, 16-byte blocks
    add_word(ACT_LOAD, 64'h0);
    add_word(ACT_LOAD, 64'h8);
    add_word(ACT_STORE, 64'h100);
    add_word(ACT_MODIFY, 64'h0);
    add_word(ACT_FETCH, 64'h0);
    add_word(ACT_LOAD, '1);
    add_word(ACT_STORE, '1);
    add_word(ACT_MODIFY, '1);
    add_word(ACT_LOAD, 64'hFFFF_FFFF_FFFF_FF00);
    add_word(ACT_FETCH, '1);
    add_word(ACT_LOAD, 64'h5555_5555_5555_5555);
    add_word(ACT_STORE, 64'hAAAA_AAAA_AAAA_AAAA);
    // fill one set of eight ways past capacity
    add_cfg(CFG_SET_BITS, 6'd8);
    add_cfg(CFG_WAYS, 6'd8);
    add_cfg(CFG_BLOCK_BITS, 6'd4);
    for (int k = 1; k <= 9; k++) begin
      t = 64'(k);
      add_word(ACT_LOAD, t << 12);
    end
    add_word(ACT_LOAD, 64'h2000);
    add_word(ACT_MODIFY, 64'hA000);
    add_cfg(CFG_NONE, '1);

    add_phase(4'd8, 4'd8, 6'd4, 160);
    add_phase(4'd4, 4'd1, 6'd4, 160);
    add_phase(4'd1, 4'd2, 6'd6, 160);
    add_phase(4'd0, 4'd0, 6'd0, 160);
    add_phase(4'd15, 4'd15, 6'd63, 160);
    add_phase(4'd8, 4'd4, 6'd56, 160);
    add_phase(4'd3, 4'd8, 6'd32, 160);
    add_phase(4'd5, 4'd9, 6'd10, 160);
    add_phase(4'd2, 4'd3, 6'd5, 160);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (plan_done != plan_total) @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errs == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/sacl_pkg.sv
sv/sacl_ctrl.sv
sv/sacl_dp.sv
sv/set_assoc_cache_lru_sim.sv
tb/tb.sv
